// ----- hw/rtl/wlm_pkg.sv -----
package wlm_pkg;

  localparam int COORD_W     = 12;
  localparam int DIM_W       = 13;
  localparam int RADIUS_W    = 2;
  localparam int LEVEL_W     = 17;

  localparam int HEIGHT_LIMIT = 4096;

  localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 13'd480;
  localparam logic [RADIUS_W-1:0] RADIUS_RST       = 2'd1;
  localparam logic [LEVEL_W-1:0]  BACKGROUND_RST   = 17'd0;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_RADIUS       = 2'd2,
    REG_BACKGROUND   = 2'd3
  } cfg_reg_e;

  // control that travels with one pixel down the pipeline
  typedef struct packed {
    logic               valid;
    logic               judge;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } stage_ctrl_t;

endpackage

// ----- hw/rtl/wlm_window.sv -----
module wlm_window #(
  parameter int MAX_RADIUS     = 3,
  parameter int INTENSITY_BITS = 17
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         shift_en_i,
  input  wlm_pkg::stage_ctrl_t                         ctrl_i,
  input  logic [2*MAX_RADIUS:0][INTENSITY_BITS-1:0]    col_vals_i,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]              radius_i,
  input  logic [INTENSITY_BITS-1:0]                    bg_i,
  output wlm_pkg::stage_ctrl_t                         ctrl_o,
  output logic                                         peak_o
);

  localparam int LINES = 2 * MAX_RADIUS + 1;
  localparam int CW    = $clog2(LINES);

  logic [LINES-1:0][INTENSITY_BITS-1:0]      win_q [LINES];
  logic [MAX_RADIUS:0][INTENSITY_BITS-1:0]   cm_q  [LINES];
  logic [MAX_RADIUS:0][INTENSITY_BITS-1:0]   col_max;
  wlm_pkg::stage_ctrl_t                      ctrl_q;
  logic [INTENSITY_BITS-1:0]                 centre;
  logic [CW-1:0]                             centre_idx;

  // column maximum over rows 0..2k back, one entry per radius
  always_comb begin
    logic [INTENSITY_BITS-1:0] m;
    col_max[0] = col_vals_i[0];
    for (int k = 1; k <= MAX_RADIUS; k++) begin
      m = col_max[k-1];
      if (col_vals_i[2*k-1] > m) m = col_vals_i[2*k-1];
      if (col_vals_i[2*k] > m) m = col_vals_i[2*k];
      col_max[k] = m;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i && ctrl_i.valid) begin
      win_q[0] <= col_vals_i;
      cm_q[0]  <= col_max;
      for (int j = 1; j < LINES; j++) begin
        win_q[j] <= win_q[j-1];
        cm_q[j]  <= cm_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (shift_en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  assign centre_idx = CW'(radius_i);
  assign centre     = win_q[centre_idx][centre_idx];

  // columns beyond the live window drop out of the test
  always_comb begin
    peak_o = centre > bg_i;
    for (int j = 0; j < LINES; j++) begin
      if ((j <= 2 * int'(radius_i)) && (cm_q[j][radius_i] > centre)) peak_o = 1'b0;
    end
  end

  assign ctrl_o = ctrl_q;

endmodule

// ----- hw/rtl/windowed_local_maxima.sv -----
// A judged pixel's result is registered in stage 1, the window and m_axis.
// Throughput: one pixel per cycle unless the output stalls, set by the column
//   memory, which reads and writes one column word of all stored rows per cycle.
// Pixels within the radius of the border or in too small a frame give no beat.
// Reset: counters to column 0 row 0, registers to defaults; line memory is not
//   cleared, each entry is defined once its row has been written.
module windowed_local_maxima #(
  parameter int MAX_WIDTH      = 4096,
  parameter int MAX_RADIUS     = 3,
  parameter int INTENSITY_BITS = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] pixel_intensity, [23:17] zero
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [11:0] center_column, [23:12] center_row
  output logic        m_axis_tuser    // [0] is_peak
);

  localparam int LINES = 2 * MAX_RADIUS + 1;
  localparam int SW    = $clog2(LINES);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CNW   = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int IB    = INTENSITY_BITS;
  localparam int DW    = wlm_pkg::DIM_W;
  localparam int XW    = wlm_pkg::COORD_W;

  typedef logic [LINES-1:0][IB-1:0] word_t;

  // configuration
  logic [DW-1:0]                    fw_q, fh_q;
  logic [wlm_pkg::RADIUS_W-1:0]     rad_q;
  logic [wlm_pkg::LEVEL_W-1:0]      bg_q;

  logic [CNW-1:0] width_eff;
  logic [DW-1:0]  height_eff;
  logic [RW-1:0]  radius;
  logic [RW:0]    diam;
  logic [IB+16:0] pix_ext, bg_ext;
  logic [IB-1:0]  pix, bg;

  // position
  logic [CNW-1:0] col_q, col_0, col_p, col_inc, col_n;
  logic [DW-1:0]  row_q, row_0, row_a, row_p, row_n;
  logic [SW-1:0]  slot_q, slot_0, slot_a, slot_p, slot_n;
  logic           judge;
  logic [CNW-1:0] cx_w;
  logic [CNW+XW-1:0] cx_ext;
  logic [DW-1:0]  cy_w;

  // pipeline
  logic                  accept, stall, advance;
  wlm_pkg::stage_ctrl_t  s1_ctrl_q, s2_ctrl;
  logic [AW-1:0]         s1_col_q;
  logic [SW-1:0]         s1_slot_q;
  logic [IB-1:0]         s1_pix_q;
  logic                  fwd_q;
  word_t                 fwd_word_q, rd_word_q, cur_word, merged_word, col_vals;
  word_t                 line_mem [MAX_WIDTH];
  logic                  s2_peak;

  logic                  m_valid_q, m_peak_q;
  logic [XW-1:0]         m_cx_q, m_cy_q;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    if (s == SW'(LINES - 1)) return '0;
    return s + SW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= wlm_pkg::FRAME_WIDTH_RST;
      fh_q  <= wlm_pkg::FRAME_HEIGHT_RST;
      rad_q <= wlm_pkg::RADIUS_RST;
      bg_q  <= wlm_pkg::BACKGROUND_RST;
    end else if (cfg_we_i) begin
      unique case (wlm_pkg::cfg_reg_e'(cfg_index_i))
        wlm_pkg::REG_FRAME_WIDTH:  fw_q  <= cfg_wdata_i[DW-1:0];
        wlm_pkg::REG_FRAME_HEIGHT: fh_q  <= cfg_wdata_i[DW-1:0];
        wlm_pkg::REG_RADIUS:       rad_q <= cfg_wdata_i[wlm_pkg::RADIUS_W-1:0];
        wlm_pkg::REG_BACKGROUND:   bg_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q == '0) width_eff = CNW'(1);
    else if (int'(fw_q) > MAX_WIDTH) width_eff = CNW'(MAX_WIDTH);
    else width_eff = CNW'(fw_q);
    if (fh_q == '0) height_eff = DW'(1);
    else if (int'(fh_q) > wlm_pkg::HEIGHT_LIMIT) height_eff = DW'(wlm_pkg::HEIGHT_LIMIT);
    else height_eff = fh_q;
    if (int'(rad_q) > MAX_RADIUS) radius = RW'(MAX_RADIUS);
    else radius = RW'(rad_q);
  end

  assign diam    = {radius, 1'b0};
  assign pix_ext = {{IB{1'b0}}, s_axis_tdata[16:0]};
  assign bg_ext  = {{IB{1'b0}}, bg_q};
  assign pix     = pix_ext[IB-1:0];
  assign bg      = bg_ext[IB-1:0];

  // position of this pixel, then of the next one
  always_comb begin
    col_0  = s_axis_tuser ? '0 : col_q;
    row_0  = s_axis_tuser ? '0 : row_q;
    slot_0 = s_axis_tuser ? '0 : slot_q;
    if (col_0 >= width_eff) begin
      col_p  = '0;
      row_a  = row_0 + DW'(1);
      slot_a = slot_inc(slot_0);
    end else begin
      col_p  = col_0;
      row_a  = row_0;
      slot_a = slot_0;
    end
    if (row_a >= height_eff) begin
      row_p  = '0;
      slot_p = '0;
    end else begin
      row_p  = row_a;
      slot_p = slot_a;
    end
    col_inc = col_p + CNW'(1);
    if (col_inc >= width_eff) begin
      col_n  = '0;
      row_n  = row_p + DW'(1);
      slot_n = slot_inc(slot_p);
      if (row_n >= height_eff) begin
        row_n  = '0;
        slot_n = '0;
      end
    end else begin
      col_n  = col_inc;
      row_n  = row_p;
      slot_n = slot_p;
    end
  end

  assign judge  = (col_p >= CNW'(diam)) && (row_p >= DW'(diam));
  assign cx_w   = col_p - CNW'(radius);
  assign cx_ext = {{XW{1'b0}}, cx_w};
  assign cy_w   = row_p - DW'(radius);

  // hold the pipe only when a result must enter a full output register
  assign stall         = m_valid_q && !m_axis_tready && s2_ctrl.valid && s2_ctrl.judge;
  assign advance       = !stall;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      slot_q    <= '0;
      s1_ctrl_q <= '0;
      fwd_q     <= 1'b0;
    end else if (advance) begin
      if (accept) begin
        col_q  <= col_n;
        row_q  <= row_n;
        slot_q <= slot_n;
      end
      s1_ctrl_q.valid <= accept;
      s1_ctrl_q.judge <= judge;
      s1_ctrl_q.cx    <= cx_ext[XW-1:0];
      s1_ctrl_q.cy    <= cy_w[XW-1:0];
      // the word being written this edge is not yet in the memory read
      fwd_q           <= s1_ctrl_q.valid && (s1_col_q == col_p[AW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_col_q   <= col_p[AW-1:0];
      s1_slot_q  <= slot_p;
      s1_pix_q   <= pix;
      fwd_word_q <= merged_word;
      rd_word_q  <= line_mem[col_p[AW-1:0]];
      if (s1_ctrl_q.valid) line_mem[s1_col_q] <= merged_word;
    end
  end

  always_comb begin
    int ridx;
    cur_word                = fwd_q ? fwd_word_q : rd_word_q;
    merged_word             = cur_word;
    merged_word[s1_slot_q]  = s1_pix_q;
    for (int k = 0; k < LINES; k++) begin
      if (int'(s1_slot_q) >= k) ridx = int'(s1_slot_q) - k;
      else ridx = int'(s1_slot_q) + LINES - k;
      col_vals[k] = merged_word[SW'(ridx)];
    end
  end

  wlm_window #(
    .MAX_RADIUS     (MAX_RADIUS),
    .INTENSITY_BITS (INTENSITY_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (advance),
    .ctrl_i     (s1_ctrl_q),
    .col_vals_i (col_vals),
    .radius_i   (radius),
    .bg_i       (bg),
    .ctrl_o     (s2_ctrl),
    .peak_o     (s2_peak)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance && s2_ctrl.valid && s2_ctrl.judge) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_ctrl.valid && s2_ctrl.judge) begin
      m_cx_q   <= s2_ctrl.cx;
      m_cy_q   <= s2_ctrl.cy;
      m_peak_q <= s2_peak;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_cy_q, m_cx_q};
  assign m_axis_tuser  = m_peak_q;

  a_out_from_judge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s2_ctrl.valid && s2_ctrl.judge))
    else $error("output beat without a judged pixel");

  a_stall_holds_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(s2_ctrl))
    else $error("window stage moved while output stalled");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < SW'(LINES))
    else $error("row slot out of range");

  a_col_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < CNW'(MAX_WIDTH))
    else $error("column beyond line memory");

endmodule
